/* src/fastq_quality_encoding_detector_top_macros.svh */
// Assertion macros for the FASTQ quality encoding detector.
// Needs no other file; included by modules that carry assertions.
`ifndef FASTQ_QUALITY_ENCODING_DETECTOR_TOP_MACROS_SVH
`define FASTQ_QUALITY_ENCODING_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define FQED_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define FQED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/fqed_pkg.sv */
// Shared types and constants for the FASTQ quality encoding detector.
// No dependencies.
package fqed_pkg;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_TRUNC_SEQ  = 2'd2,
        ST_TRUNC_QUAL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ENC_PHRED33  = 2'd0,
        ENC_PHRED64  = 2'd1,
        ENC_SOLEXA64 = 2'd2
    } encoding_t;

    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [7:0] Q_PHRED33_LO = 8'd33;
    localparam logic [7:0] Q_SOLEXA_LO  = 8'd59;
    localparam logic [7:0] Q_PHRED64_LO = 8'd64;
    localparam logic [7:0] Q_HI         = 8'd126;

    // Raw verdict from the parser: state snapshot at the moment of emission.
    typedef struct packed {
        logic        fire;
        status_t     status;
        logic [31:0] count_lo;
        logic        has_records;
        logic [7:0]  qmin;
        logic [7:0]  qmax;
        logic        any_qual;
    } emit_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] records_counted;
        logic [7:0]  quality_min;
        logic [7:0]  quality_max;
        logic        fits_phred33;
        logic        fits_phred64;
        logic        fits_solexa64;
        encoding_t   encoding_guess;
        logic        ambiguous;
    } verdict_t;

endpackage

/* src/fastq_quality_encoding_detector_top.sv */
// An item is registered on acceptance and parsed once the result register can
// absorb a verdict; its verdict, if any, is loaded into the result register by the edge that parses it.
// Throughput: one byte per cycle while the result side does not stall.
// Stalls on the result side hold the input register and in turn raise in_stall.
// Reset (async, active low) clears the parser, both valid flags and record_limit.
module fastq_quality_encoding_detector_top #(
    parameter int COUNT_BITS  = 32,
    parameter int LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] records_counted,
    output logic [7:0]  quality_min,
    output logic [7:0]  quality_max,
    output logic        fits_phred33,
    output logic        fits_phred64,
    output logic        fits_solexa64,
    output logic [1:0]  encoding_guess,
    output logic        ambiguous
);
    import fqed_pkg::*;

    logic [31:0] limit_reg;
    logic        in_valid_reg;
    logic        mode_reg;
    logic [7:0]  byte_reg;
    logic        out_valid_reg;
    verdict_t    out_reg;
    logic        advance;
    logic        in_take;
    emit_t       emit;
    verdict_t    verdict;

    // Parse the held item when the result register can absorb a verdict.
    assign advance  = in_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall = in_valid_reg & ~advance;
    assign in_take  = in_valid & ~in_stall;

    fqed_parser #(
        .COUNT_BITS  (COUNT_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .mode         (mode_reg),
        .data_byte    (byte_reg),
        .record_limit (limit_reg),
        .emit         (emit)
    );

    fqed_verdict u_verdict (
        .emit    (emit),
        .verdict (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (emit.fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg <= mode;
            byte_reg <= data_byte;
        end
        if (emit.fire)
            out_reg <= verdict;
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_reg.status;
    assign records_counted  = out_reg.records_counted;
    assign quality_min      = out_reg.quality_min;
    assign quality_max      = out_reg.quality_max;
    assign fits_phred33     = out_reg.fits_phred33;
    assign fits_phred64     = out_reg.fits_phred64;
    assign fits_solexa64    = out_reg.fits_solexa64;
    assign encoding_guess   = out_reg.encoding_guess;
    assign ambiguous        = out_reg.ambiguous;

endmodule

/* src/fqed_parser.sv */
// FASTQ record parser: phase, lengths, record count and quality range.
// Depends on fqed_pkg and the assertion macro header.
`include "fastq_quality_encoding_detector_top_macros.svh"

module fqed_parser #(
    parameter int COUNT_BITS  = 32,
    parameter int LENGTH_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              mode,
    input  logic [7:0]        data_byte,
    input  logic [31:0]       record_limit,
    output fqed_pkg::emit_t   emit
);
    import fqed_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR_START  = 3'd0,
        PH_HDR_LINE   = 3'd1,
        PH_SEQ        = 3'd2,
        PH_PLUS_LINE  = 3'd3,
        PH_QUAL       = 3'd4,
        PH_DONE       = 3'd5
    } phase_t;

    localparam int CMP_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;
    localparam int LW1   = LENGTH_BITS + 1;

    phase_t                 phase_reg, phase_next, phase_v;
    logic [LENGTH_BITS-1:0] seq_reg, seq_next, seq_v;
    logic [LENGTH_BITS-1:0] qual_reg, qual_next, qual_v;
    logic                   line_reg, line_next, line_v;
    logic                   pend_reg, pend_next, pend_v;
    logic [COUNT_BITS-1:0]  count_reg, count_next, count_v;
    logic [7:0]             min_reg, min_next, min_v;
    logic [7:0]             max_reg, max_next, max_v;
    logic                   anyq_reg, anyq_next, anyq_v;

    logic                   fire;
    status_t                status;
    logic                   done_rec;
    logic                   started;
    logic                   is_nl;
    logic                   is_cr;
    logic                   cr_close;
    logic [1:0]             content_inc;
    logic [LENGTH_BITS-1:0] q_close;
    logic [COUNT_BITS-1:0]  count_inc;
    logic                   limit_hit;
    logic                   limit_after;

    function automatic logic [LENGTH_BITS-1:0] sat_add(
        input logic [LENGTH_BITS-1:0] v,
        input logic [1:0]             inc
    );
        logic [LENGTH_BITS:0] s;
        s = {1'b0, v} + LW1'(inc);
        return s[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : s[LENGTH_BITS-1:0];
    endfunction

    function automatic logic [7:0] take_min(
        input logic [7:0] cur,
        input logic [7:0] c,
        input logic       act
    );
        return (act && (c < cur)) ? c : cur;
    endfunction

    function automatic logic [7:0] take_max(
        input logic [7:0] cur,
        input logic [7:0] c,
        input logic       act
    );
        return (act && (c > cur)) ? c : cur;
    endfunction

    assign started     = line_reg | pend_reg;
    assign is_nl       = (data_byte == CH_NL);
    assign is_cr       = (data_byte == CH_CR);
    assign cr_close    = pend_reg & ~line_reg;
    assign content_inc = {1'b0, pend_reg} + {1'b0, ~is_cr};
    assign q_close     = sat_add(qual_reg, {1'b0, cr_close});
    assign count_inc   = (&count_reg) ? count_reg : count_reg + 1'b1;
    assign limit_hit   = (record_limit != '0) &&
                         (CMP_W'(count_reg) >= CMP_W'(record_limit));
    assign limit_after = (record_limit != '0) &&
                         (CMP_W'(count_inc) >= CMP_W'(record_limit));

    always_comb
    begin
        phase_v  = phase_reg;
        seq_v    = seq_reg;
        qual_v   = qual_reg;
        line_v   = line_reg;
        pend_v   = pend_reg;
        count_v  = count_reg;
        min_v    = min_reg;
        max_v    = max_reg;
        anyq_v   = anyq_reg;
        fire     = 1'b0;
        status   = ST_OK;
        done_rec = 1'b0;

        if (mode)
        begin
            case (phase_reg)
                PH_HDR_START:
                begin
                    fire = 1'b1;
                end
                PH_HDR_LINE, PH_SEQ:
                begin
                    fire   = 1'b1;
                    status = ST_TRUNC_SEQ;
                end
                PH_PLUS_LINE:
                begin
                    fire = 1'b1;
                    if (seq_reg == '0)
                        done_rec = 1'b1;
                    else
                        status = ST_TRUNC_QUAL;
                end
                PH_QUAL:
                begin
                    fire   = 1'b1;
                    status = ST_TRUNC_QUAL;
                    // Close the partial line as if a newline had come.
                    if (started)
                    begin
                        qual_v = q_close;
                        min_v  = take_min(min_reg, CH_CR, cr_close);
                        max_v  = take_max(max_reg, CH_CR, cr_close);
                        anyq_v = anyq_reg | cr_close;
                        if (q_close == seq_reg)
                        begin
                            done_rec = 1'b1;
                            status   = ST_OK;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            case (phase_reg)
                PH_HDR_START:
                begin
                    if (limit_hit)
                        fire = 1'b1;
                    else if (data_byte == CH_AT)
                        phase_v = PH_HDR_LINE;
                    else
                    begin
                        fire   = 1'b1;
                        status = ST_BAD_HEADER;
                    end
                end
                PH_HDR_LINE:
                begin
                    if (is_nl)
                    begin
                        phase_v = PH_SEQ;
                        seq_v   = '0;
                        line_v  = 1'b0;
                        pend_v  = 1'b0;
                    end
                end
                PH_SEQ:
                begin
                    if (is_nl)
                    begin
                        seq_v  = sat_add(seq_reg, {1'b0, cr_close});
                        line_v = 1'b0;
                        pend_v = 1'b0;
                    end
                    else if (!started && data_byte == CH_PLUS)
                        phase_v = PH_PLUS_LINE;
                    else
                    begin
                        seq_v  = sat_add(seq_reg, content_inc);
                        line_v = line_reg | (content_inc != 2'd0);
                        pend_v = is_cr;
                    end
                end
                PH_PLUS_LINE:
                begin
                    if (is_nl)
                    begin
                        if (seq_reg == '0)
                            done_rec = 1'b1;
                        else
                        begin
                            phase_v = PH_QUAL;
                            qual_v  = '0;
                            line_v  = 1'b0;
                            pend_v  = 1'b0;
                        end
                    end
                end
                PH_QUAL:
                begin
                    if (is_nl)
                    begin
                        qual_v = q_close;
                        min_v  = take_min(min_reg, CH_CR, cr_close);
                        max_v  = take_max(max_reg, CH_CR, cr_close);
                        anyq_v = anyq_reg | cr_close;
                        line_v = 1'b0;
                        pend_v = 1'b0;
                        if (q_close == seq_reg)
                            done_rec = 1'b1;
                        else if (q_close > seq_reg)
                        begin
                            fire   = 1'b1;
                            status = ST_TRUNC_QUAL;
                        end
                    end
                    else
                    begin
                        // A held return commits first, then the new byte.
                        qual_v = sat_add(qual_reg, content_inc);
                        min_v  = take_min(take_min(min_reg, CH_CR, pend_reg),
                                          data_byte, ~is_cr);
                        max_v  = take_max(take_max(max_reg, CH_CR, pend_reg),
                                          data_byte, ~is_cr);
                        anyq_v = anyq_reg | (content_inc != 2'd0);
                        line_v = line_reg | (content_inc != 2'd0);
                        pend_v = is_cr;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (done_rec)
        begin
            count_v = count_inc;
            seq_v   = '0;
            qual_v  = '0;
            line_v  = 1'b0;
            pend_v  = 1'b0;
            phase_v = PH_HDR_START;
            if (limit_after)
                fire = 1'b1;
        end

        if (fire)
            phase_v = PH_DONE;
    end

    // End of file re-arms everything but the limit.
    always_comb
    begin
        if (mode)
        begin
            phase_next = PH_HDR_START;
            seq_next   = '0;
            qual_next  = '0;
            line_next  = 1'b0;
            pend_next  = 1'b0;
            count_next = '0;
            min_next   = 8'hFF;
            max_next   = 8'h00;
            anyq_next  = 1'b0;
        end
        else
        begin
            phase_next = phase_v;
            seq_next   = seq_v;
            qual_next  = qual_v;
            line_next  = line_v;
            pend_next  = pend_v;
            count_next = count_v;
            min_next   = min_v;
            max_next   = max_v;
            anyq_next  = anyq_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR_START;
            seq_reg   <= '0;
            qual_reg  <= '0;
            line_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            count_reg <= '0;
            min_reg   <= 8'hFF;
            max_reg   <= 8'h00;
            anyq_reg  <= 1'b0;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            seq_reg   <= seq_next;
            qual_reg  <= qual_next;
            line_reg  <= line_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            anyq_reg  <= anyq_next;
        end
    end

    always_comb
    begin
        emit.fire        = fire & en;
        emit.status      = status;
        emit.count_lo    = 32'(count_v);
        emit.has_records = (count_v != '0);
        emit.qmin        = min_v;
        emit.qmax        = max_v;
        emit.any_qual    = anyq_v;
    end

    `FQED_ASSERT_NEXT(a_data_verdict_parks, clk, rst_n, en && fire && !mode, phase_reg == PH_DONE, "verdict on a data byte did not park the parser")
    `FQED_ASSERT_NEXT(a_eof_rearms, clk, rst_n, en && mode, phase_reg == PH_HDR_START && count_reg == '0, "end of file did not re-arm the parser")
    `FQED_ASSERT_IMP(a_done_silent, clk, rst_n, en && !mode && phase_reg == PH_DONE, !fire, "second verdict before end of file")
    `FQED_ASSERT_NEXT(a_idle_holds, clk, rst_n, !en, $stable(phase_reg) && $stable(count_reg), "parser state moved without an item")

endmodule

/* src/fqed_verdict.sv */
// Verdict encoder: turns the raw range and status into encoding flags and a guess.
// Depends on fqed_pkg.
module fqed_verdict (
    input  fqed_pkg::emit_t    emit,
    output fqed_pkg::verdict_t verdict
);
    import fqed_pkg::*;

    logic       range_ok;
    logic [7:0] lo;
    logic [7:0] hi;
    logic       f33;

    assign range_ok = (emit.status == ST_OK) && emit.any_qual && emit.has_records;
    assign lo       = range_ok ? emit.qmin : 8'h00;
    assign hi       = range_ok ? emit.qmax : 8'h00;
    assign f33      = range_ok && (lo >= Q_PHRED33_LO) && (hi <= Q_HI);

    always_comb
    begin
        verdict.status          = emit.status;
        verdict.records_counted = emit.count_lo;
        verdict.quality_min     = lo;
        verdict.quality_max     = hi;
        verdict.fits_phred33    = f33;
        verdict.fits_phred64    = range_ok && (lo >= Q_PHRED64_LO) && (hi <= Q_HI);
        verdict.fits_solexa64   = range_ok && (lo >= Q_SOLEXA_LO) && (hi <= Q_HI);
        verdict.encoding_guess  = ENC_PHRED33;
        verdict.ambiguous       = 1'b0;
        if (range_ok && lo >= Q_PHRED64_LO)
        begin
            verdict.encoding_guess = ENC_PHRED64;
            verdict.ambiguous      = f33;
        end
        else if (range_ok && lo >= Q_SOLEXA_LO)
        begin
            verdict.encoding_guess = ENC_SOLEXA64;
            verdict.ambiguous      = f33;
        end
    end

endmodule

/* verif/fqed_verdict_checker.sv */
// Verdict checker for the FASTQ quality encoding detector testbench.
// Depends on fqed_pkg. Watches both channels, predicts each verdict from the
// accepted bytes and compares it field by field with what the block offers.
module fqed_verdict_checker #(
    parameter int COUNT_BITS  = 32,
    parameter int LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        mode,
    input  logic [7:0]  data_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic [31:0] records_counted,
    input  logic [7:0]  quality_min,
    input  logic [7:0]  quality_max,
    input  logic        fits_phred33,
    input  logic        fits_phred64,
    input  logic        fits_solexa64,
    input  logic [1:0]  encoding_guess,
    input  logic        ambiguous,
    output int          fail_count,
    output int          outstanding
);
    import fqed_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR_START,
        PH_HDR_LINE,
        PH_SEQ,
        PH_PLUS_LINE,
        PH_QUAL,
        PH_DONE
    } parse_phase_t;

    logic [31:0]            record_limit_q;
    parse_phase_t           phase;
    logic [LENGTH_BITS-1:0] seq_len;
    logic [LENGTH_BITS-1:0] qual_total;
    logic                   line_open;
    logic                   cr_held;
    logic [COUNT_BITS-1:0]  rec_cnt;
    logic [7:0]             q_lo;
    logic [7:0]             q_hi;
    logic                   q_seen;
    verdict_t               verdict_q[$];

    function automatic void clear_parse();
        phase      = PH_HDR_START;
        seq_len    = '0;
        qual_total = '0;
        line_open  = 1'b0;
        cr_held    = 1'b0;
        rec_cnt    = '0;
        q_lo       = 8'hFF;
        q_hi       = 8'h00;
        q_seen     = 1'b0;
    endfunction

    function automatic bit limit_hit();
        return record_limit_q != 0 && rec_cnt >= record_limit_q;
    endfunction

    function automatic void issue_verdict(status_t st);
        verdict_t v;
        logic     f33;
        v = '0;
        v.status = st;
        v.records_counted = 32'(rec_cnt);
        // The range and the flags only mean something for a clean run with data.
        if (st == ST_OK && q_seen && rec_cnt != 0)
        begin
            f33 = (q_lo >= Q_PHRED33_LO) && (q_hi <= Q_HI);
            v.quality_min   = q_lo;
            v.quality_max   = q_hi;
            v.fits_phred33  = f33;
            v.fits_phred64  = (q_lo >= Q_PHRED64_LO) && (q_hi <= Q_HI);
            v.fits_solexa64 = (q_lo >= Q_SOLEXA_LO) && (q_hi <= Q_HI);
            if (q_lo < Q_SOLEXA_LO)
            begin
                v.encoding_guess = ENC_PHRED33;
            end
            else if (q_lo < Q_PHRED64_LO)
            begin
                v.encoding_guess = ENC_SOLEXA64;
                v.ambiguous      = f33;
            end
            else
            begin
                v.encoding_guess = ENC_PHRED64;
                v.ambiguous      = f33;
            end
        end
        verdict_q.push_back(v);
        phase = PH_DONE;
    endfunction

    function automatic void commit_byte(logic [7:0] c);
        line_open = 1'b1;
        if (phase == PH_SEQ)
        begin
            if (seq_len != '1)
                seq_len++;
        end
        else
        begin
            if (qual_total != '1)
                qual_total++;
            if (c < q_lo)
                q_lo = c;
            if (c > q_hi)
                q_hi = c;
            q_seen = 1'b1;
        end
    endfunction

    // Hold a carriage return until the next byte shows it is not the line end.
    function automatic void take_content(logic [7:0] b);
        if (cr_held)
        begin
            commit_byte(CH_CR);
            cr_held = 1'b0;
        end
        if (b == CH_CR)
            cr_held = 1'b1;
        else
            commit_byte(b);
    endfunction

    function automatic void close_line();
        if (cr_held && !line_open)
            commit_byte(CH_CR);
        cr_held   = 1'b0;
        line_open = 1'b0;
    endfunction

    function automatic bit record_done();
        if (rec_cnt != '1)
            rec_cnt++;
        seq_len    = '0;
        qual_total = '0;
        line_open  = 1'b0;
        cr_held    = 1'b0;
        phase      = PH_HDR_START;
        if (limit_hit())
        begin
            issue_verdict(ST_OK);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit plus_done();
        if (seq_len == 0)
            return record_done();
        phase      = PH_QUAL;
        qual_total = '0;
        line_open  = 1'b0;
        cr_held    = 1'b0;
        return 1'b0;
    endfunction

    function automatic bit qual_line_end();
        close_line();
        if (qual_total < seq_len)
            return 1'b0;
        if (qual_total == seq_len)
            return record_done();
        issue_verdict(ST_TRUNC_QUAL);
        return 1'b1;
    endfunction

    function automatic void parse_item(logic is_eof, logic [7:0] b);
        bit started;
        bit fired;
        started = line_open || cr_held;
        fired   = 1'b0;
        if (is_eof)
        begin
            case (phase)
                PH_HDR_START:
                    issue_verdict(ST_OK);
                PH_HDR_LINE, PH_SEQ:
                    issue_verdict(ST_TRUNC_SEQ);
                PH_PLUS_LINE:
                begin
                    fired = plus_done();
                    if (!fired)
                        issue_verdict((phase == PH_HDR_START) ? ST_OK : ST_TRUNC_QUAL);
                end
                PH_QUAL:
                begin
                    // A partial last line counts as if a newline had ended it.
                    if (started)
                        fired = qual_line_end();
                    if (!fired)
                        issue_verdict((phase == PH_HDR_START) ? ST_OK : ST_TRUNC_QUAL);
                end
                default:
                    ;
            endcase
            clear_parse();
        end
        else
        begin
            case (phase)
                PH_HDR_START:
                begin
                    if (limit_hit())
                        issue_verdict(ST_OK);
                    else if (b == CH_AT)
                        phase = PH_HDR_LINE;
                    else
                        issue_verdict(ST_BAD_HEADER);
                end
                PH_HDR_LINE:
                begin
                    if (b == CH_NL)
                    begin
                        phase     = PH_SEQ;
                        seq_len   = '0;
                        line_open = 1'b0;
                        cr_held   = 1'b0;
                    end
                end
                PH_SEQ:
                begin
                    if (b == CH_NL)
                        close_line();
                    else if (!started && b == CH_PLUS)
                        phase = PH_PLUS_LINE;
                    else
                        take_content(b);
                end
                PH_PLUS_LINE:
                begin
                    if (b == CH_NL)
                        void'(plus_done());
                end
                PH_QUAL:
                begin
                    if (b == CH_NL)
                        void'(qual_line_end());
                    else
                        take_content(b);
                end
                default:
                    ;
            endcase
        end
    endfunction

    task automatic report_error(string msg);
        $display("ERROR: %s", msg);
        fail_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want_val);
        if (got !== want_val)
            report_error($sformatf("%s: got %0d, expected %0d", name, got, want_val));
    endtask

    // Compare before predicting: a verdict leaving now never comes from this edge's item.
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            record_limit_q = '0;
            clear_parse();
            verdict_q.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    report_error($sformatf("verdict with none pending: status %0d, records %0d",
                                           status, records_counted));
                end
                else
                begin
                    want = verdict_q.pop_front();
                    check_field("status", status, want.status);
                    check_field("records_counted", records_counted, want.records_counted);
                    check_field("quality_min", quality_min, want.quality_min);
                    check_field("quality_max", quality_max, want.quality_max);
                    check_field("fits_phred33", fits_phred33, want.fits_phred33);
                    check_field("fits_phred64", fits_phred64, want.fits_phred64);
                    check_field("fits_solexa64", fits_solexa64, want.fits_solexa64);
                    check_field("encoding_guess", encoding_guess, want.encoding_guess);
                    check_field("ambiguous", ambiguous, want.ambiguous);
                end
            end
            if (cfg_wr_en)
                record_limit_q = cfg_wr_data;
            if (in_valid && !in_stall)
                parse_item(mode, data_byte);
            outstanding = verdict_q.size();
        end
    end

endmodule

/* verif/fastq_quality_encoding_detector_top_tb.sv */
// Testbench top for the FASTQ quality encoding detector: clock, reset, FASTQ
// byte stimulus, record limit writes and receiver stalls; verdict from the count.
// Depends on fqed_pkg, the block and fqed_verdict_checker.
module fastq_quality_encoding_detector_top_tb;
    import fqed_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 1850;
    localparam int MIN_FILES    = 40;

    typedef struct packed {
        logic       eof;
        logic [7:0] value;
    } byte_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] records_counted;
    logic [7:0]  quality_min;
    logic [7:0]  quality_max;
    logic        fits_phred33;
    logic        fits_phred64;
    logic        fits_solexa64;
    logic [1:0]  encoding_guess;
    logic        ambiguous;

    int          fail_count;
    int          outstanding;
    int          items_sent;
    int          hold_requests;
    int          cycle_count;
    bit          quiet_send;
    byte_item_t  file_q[$];

    fastq_quality_encoding_detector_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .data_byte        (data_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .records_counted  (records_counted),
        .quality_min      (quality_min),
        .quality_max      (quality_max),
        .fits_phred33     (fits_phred33),
        .fits_phred64     (fits_phred64),
        .fits_solexa64    (fits_solexa64),
        .encoding_guess   (encoding_guess),
        .ambiguous        (ambiguous)
    );

    fqed_verdict_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .data_byte        (data_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .records_counted  (records_counted),
        .quality_min      (quality_min),
        .quality_max      (quality_max),
        .fits_phred33     (fits_phred33),
        .fits_phred64     (fits_phred64),
        .fits_solexa64    (fits_solexa64),
        .encoding_guess   (encoding_guess),
        .ambiguous        (ambiguous),
        .fail_count       (fail_count),
        .outstanding      (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_in(int lo, int hi, bit no_cr, bit no_plus);
        logic [7:0] b;
        b = 8'($urandom_range(hi, lo));
        while (b == CH_NL || (no_cr && b == CH_CR) || (no_plus && b == CH_PLUS))
            b = 8'($urandom_range(hi, lo));
        return b;
    endfunction

    function automatic logic [7:0] pick_base();
        case ($urandom_range(0, 4))
            0: return "A";
            1: return "C";
            2: return "G";
            3: return "T";
            default: return "N";
        endcase
    endfunction

    task automatic add_byte(logic [7:0] b);
        file_q.push_back('{eof: 1'b0, value: b});
    endtask

    task automatic add_eof();
        file_q.push_back('{eof: 1'b1, value: 8'($urandom_range(0, 255))});
    endtask

    // Offer one item and hold it until the block takes it.
    task automatic drive_item(logic is_eof, logic [7:0] b);
        int gap;
        gap = quiet_send ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= is_eof;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic flush_file();
        foreach (file_q[i])
            drive_item(file_q[i].eof, file_q[i].value);
        file_q.delete();
    endtask

    // Drop valid, drain all pending verdicts, then let the pipeline settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(logic [31:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic add_line(int n, bit is_seq, int lo, int hi);
        for (int i = 0; i < n; i++)
        begin
            if (!is_seq)
                add_byte(pick_in(lo, hi, 1'b1, 1'b0));
            else if ($urandom_range(0, 99) < 80)
                add_byte(pick_base());
            else
                add_byte(pick_in(0, 255, 1'b1, i == 0));
        end
        // A trailing CR on a line with content is dropped by the parser.
        if ($urandom_range(0, 3) == 0)
            add_byte(CH_CR);
        add_byte(CH_NL);
    endtask

    task automatic add_block(int total, bit is_seq, int lo, int hi);
        int left;
        int n;
        left = total;
        while (left > 0)
        begin
            if ($urandom_range(0, 9) == 0)
                add_byte(CH_NL);
            n = $urandom_range(1, left);
            add_line(n, is_seq, lo, hi);
            left -= n;
        end
    endtask

    task automatic add_record(int lo, int hi, int extra);
        int seq_n;
        int lone_cr;
        add_byte(CH_AT);
        repeat ($urandom_range(0, 4)) add_byte(pick_in(0, 255, 1'b0, 1'b0));
        add_byte(CH_NL);
        seq_n   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
        lone_cr = (seq_n > 0 && $urandom_range(0, 9) == 0) ? 1 : 0;
        add_block(seq_n, 1'b1, 0, 255);
        // A one-byte line keeps its CR, so it adds to the sequence length.
        if (lone_cr != 0)
        begin
            add_byte(CH_CR);
            add_byte(CH_NL);
        end
        add_byte(CH_PLUS);
        repeat ($urandom_range(0, 3)) add_byte(pick_in(0, 255, 1'b0, 1'b0));
        add_byte(CH_NL);
        add_block(seq_n + lone_cr + extra, 1'b0, lo, hi);
    endtask

    task automatic build_file();
        int         lo;
        int         hi;
        int         nrec;
        int         flaw;
        int         keep;
        logic [7:0] b;
        case ($urandom_range(0, 6))
            0: begin lo = 33; hi = 73;  end
            1: begin lo = 64; hi = 104; end
            2: begin lo = 59; hi = 104; end
            3: begin lo = 64; hi = 126; end
            4: begin lo = 33; hi = 126; end
            5: begin lo = 0;  hi = 255; end
            default:
            begin
                lo = $urandom_range(59, 66);
                hi = lo + $urandom_range(0, 60);
            end
        endcase
        nrec = $urandom_range(1, 4);
        flaw = ($urandom_range(0, 99) < 72) ? 0 : $urandom_range(1, 5);
        for (int r = 0; r < nrec; r++)
            add_record(lo, hi, (flaw == 3 && r == nrec - 1) ? $urandom_range(1, 2) : 0);
        case (flaw)
            1:
            begin
                // header line that does not start with '@'
                b = 8'($urandom_range(0, 255));
                while (b == CH_AT)
                    b = 8'($urandom_range(0, 255));
                add_byte(b);
                repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
            end
            2:
            begin
                keep = $urandom_range(0, file_q.size() - 1);
                while (file_q.size() > keep)
                    void'(file_q.pop_back());
            end
            4:
                repeat ($urandom_range(3, 15)) add_byte(8'($urandom_range(0, 255)));
            5:
            begin
                // end of file inside the last line
                if (file_q[$].value == CH_NL)
                    void'(file_q.pop_back());
            end
            default:
                ;
        endcase
        add_eof();
        quiet_send = ($urandom_range(0, 4) == 0);
        flush_file();
    endtask

    // Receiver: random stall runs, quiet stretches, and long hold-offs on request.
    initial
    begin
        int run_left;
        int hold_left;
        int holds_done;
        bit stall_lvl;
        run_left   = 0;
        hold_left  = 0;
        holds_done = 0;
        stall_lvl  = 1'b0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        stall_lvl = 1'b0;
                        run_left  = $urandom_range(50, 200);
                    end
                    else
                    begin
                        stall_lvl = ($urandom_range(0, 3) == 0);
                        run_left  = pick_gap() + 1;
                    end
                end
                run_left--;
                out_stall <= stall_lvl;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int         phase_idx;
        int         files;
        logic [31:0] limit_val;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_valid      = 1'b0;
        mode          = 1'b0;
        data_byte     = '0;
        items_sent    = 0;
        hold_requests = 0;
        quiet_send    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty file, then a bad header
        add_eof();
        add_byte("x");
        add_eof();
        // extreme header bytes, trailing CR on a sequence line, widest phred33 range
        add_byte(CH_AT);
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(CH_NL);
        add_byte("A");
        add_byte("C");
        add_byte(CH_CR);
        add_byte(CH_NL);
        add_byte(CH_PLUS);
        add_byte(CH_NL);
        add_byte(Q_PHRED33_LO);
        add_byte(Q_HI);
        add_byte(CH_NL);
        add_eof();
        // empty sequence record ends at its '+' line
        add_byte(CH_AT);
        add_byte(CH_NL);
        add_byte(CH_PLUS);
        add_byte(CH_NL);
        flush_file();
        // lower the limit to the count while a header is awaited
        write_limit(32'd1);
        add_byte("Z");
        add_eof();
        // end of file inside the header line
        add_byte(CH_AT);
        add_eof();
        flush_file();

        items_sent = 0;
        phase_idx  = 0;
        files      = 0;
        while (items_sent < RANDOM_ITEMS || files < MIN_FILES)
        begin
            case (phase_idx % 7)
                0: limit_val = 32'd0;
                1: limit_val = 32'd1;
                2: limit_val = 32'd2;
                3: limit_val = 32'hFFFF_FFFF;
                4: limit_val = 32'($urandom_range(1, 4));
                5: limit_val = $urandom();
                default: limit_val = 32'd3;
            endcase
            write_limit(limit_val);
            // back up the result side so the block fills and stalls its input
            if (phase_idx == 0 || phase_idx == 9)
                hold_requests++;
            repeat ($urandom_range(3, 7))
            begin
                build_file();
                files++;
            end
            phase_idx++;
        end

        wait_idle();
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/fqed_pkg.sv
src/fqed_parser.sv
src/fqed_verdict.sv
src/fastq_quality_encoding_detector_top.sv
verif/fqed_verdict_checker.sv
verif/fastq_quality_encoding_detector_top_tb.sv
